FILE: rtl/spin_turn_wheel_controller_top_defines.svh
// Assertion macros shared by the turn controller modules.
`ifndef SPIN_TURN_WHEEL_CONTROLLER_TOP_DEFINES_SVH
`define SPIN_TURN_WHEEL_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define STC_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define STC_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/stc_pkg.sv
// Shared types and constants of the spin turn wheel controller.
`default_nettype none

package stc_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPAN_LOAD,
    ST_SPAN_DIV,
    ST_GOAL,
    ST_CHECK,
    ST_MUL,
    ST_DIV_LOAD,
    ST_DIV,
    ST_PWM,
    ST_RESULT
  } state_t;

  typedef enum logic [1:0] {
    DIR_STOP = 2'b00,
    DIR_FWD  = 2'b01,
    DIR_REV  = 2'b11
  } dir_t;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic WHEEL_LEFT  = 1'b0;
  localparam logic WHEEL_RIGHT = 1'b1;

  localparam logic [1:0] REG_TREAD   = 2'd0;
  localparam logic [1:0] REG_RADIUS  = 2'd1;
  localparam logic [1:0] REG_MIN_PWM = 2'd2;

  localparam logic [9:0] TREAD_RST   = 10'd137;
  localparam logic [7:0] RADIUS_RST  = 8'd45;
  localparam logic [6:0] MIN_PWM_RST = 7'd20;

  localparam logic [6:0] PWM_LIMIT = 7'd100;

  // quotient bits produced by the divider for span and for drive
  localparam int SPAN_QBITS = 32;
  localparam int PWM_QBITS  = 7;

  typedef struct packed {
    logic latch;
    logic div_load;
    logic div_span;
    logic div_step;
    logic goal_set;
    logic check;
    logic mul;
    logic pwm_set;
    logic out_load;
    logic sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic moving;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/stc_ctrl.sv
// Sequencer for start and tick requests of the turn controller.
`default_nettype none
`include "spin_turn_wheel_controller_top_defines.svh"

module stc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               cmd,
  output logic               req_stall,
  input  stc_pkg::status_t   sts_i,
  output stc_pkg::ctrl_cmd_t cmd_o
);

  stc_pkg::state_t state, state_next;
  logic sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stc_pkg::ST_IDLE;
      sel   <= stc_pkg::WHEEL_LEFT;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_next   = sel;
    case (state)
      stc_pkg::ST_IDLE: begin
        if (req_valid) begin
          sel_next   = stc_pkg::WHEEL_LEFT;
          state_next = (cmd == stc_pkg::CMD_START) ? stc_pkg::ST_SPAN_LOAD
                                                   : stc_pkg::ST_CHECK;
        end
      end
      stc_pkg::ST_SPAN_LOAD: state_next = stc_pkg::ST_SPAN_DIV;
      stc_pkg::ST_SPAN_DIV: begin
        if (sts_i.div_done) state_next = stc_pkg::ST_GOAL;
      end
      stc_pkg::ST_GOAL: state_next = stc_pkg::ST_RESULT;
      stc_pkg::ST_CHECK: begin
        if (sts_i.moving) begin
          state_next = stc_pkg::ST_MUL;
        end else if (sel == stc_pkg::WHEEL_LEFT) begin
          sel_next = stc_pkg::WHEEL_RIGHT;
        end else begin
          state_next = stc_pkg::ST_RESULT;
        end
      end
      stc_pkg::ST_MUL: state_next = stc_pkg::ST_DIV_LOAD;
      stc_pkg::ST_DIV_LOAD: state_next = stc_pkg::ST_DIV;
      stc_pkg::ST_DIV: begin
        if (sts_i.div_done) state_next = stc_pkg::ST_PWM;
      end
      stc_pkg::ST_PWM: begin
        if (sel == stc_pkg::WHEEL_LEFT) begin
          sel_next   = stc_pkg::WHEEL_RIGHT;
          state_next = stc_pkg::ST_CHECK;
        end else begin
          state_next = stc_pkg::ST_RESULT;
        end
      end
      stc_pkg::ST_RESULT: begin
        if (sts_i.out_free) state_next = stc_pkg::ST_IDLE;
      end
      default: state_next = stc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    cmd_o.sel = sel;
    req_stall = (state != stc_pkg::ST_IDLE);
    case (state)
      stc_pkg::ST_IDLE:      cmd_o.latch = req_valid;
      stc_pkg::ST_SPAN_LOAD: begin
        cmd_o.div_load = 1'b1;
        cmd_o.div_span = 1'b1;
      end
      stc_pkg::ST_SPAN_DIV:  cmd_o.div_step = !sts_i.div_done;
      stc_pkg::ST_GOAL:      cmd_o.goal_set = 1'b1;
      stc_pkg::ST_CHECK:     cmd_o.check = 1'b1;
      stc_pkg::ST_MUL:       cmd_o.mul = 1'b1;
      stc_pkg::ST_DIV_LOAD:  cmd_o.div_load = 1'b1;
      stc_pkg::ST_DIV:       cmd_o.div_step = !sts_i.div_done;
      stc_pkg::ST_PWM:       cmd_o.pwm_set = 1'b1;
      stc_pkg::ST_RESULT:    cmd_o.out_load = sts_i.out_free;
      default:               cmd_o = '0;
    endcase
  end

  `STC_CHECK_NEXT(a_start_to_span, (req_valid && !req_stall && cmd == stc_pkg::CMD_START), (state == stc_pkg::ST_SPAN_LOAD), "start request did not enter span division")
  `STC_CHECK_NOW(a_load_needs_room, cmd_o.out_load, sts_i.out_free, "result loaded into a full output slot")
  `STC_CHECK_NEXT(a_tick_to_check, (req_valid && !req_stall && cmd == stc_pkg::CMD_TICK), (state == stc_pkg::ST_CHECK && sel == stc_pkg::WHEEL_LEFT), "tick request did not start at left wheel")

endmodule

`default_nettype wire

FILE: rtl/stc_dp.sv
// Datapath: request latches, goal and drive registers, shared serial divider.
`default_nettype none
`include "spin_turn_wheel_controller_top_defines.svh"

module stc_dp #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  stc_pkg::ctrl_cmd_t cmd_i,
  output stc_pkg::status_t   sts_o,
  input  logic [9:0]         tread,
  input  logic [7:0]         radius,
  input  logic [6:0]         min_pwm,
  input  logic               turn_right,
  input  logic signed [10:0] angle_deg,
  input  logic [6:0]         base_pwm,
  input  logic signed [31:0] left_count,
  input  logic signed [31:0] right_count,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic signed [7:0]  left_pwm,
  output logic signed [7:0]  right_pwm,
  output logic               turn_done
);

  localparam int GW  = 34 + FRAC_BITS;   // goal / remaining, signed
  localparam int RW  = GW - 1;           // positive remaining magnitude
  localparam int NW  = 41 + FRAC_BITS;   // dividend
  localparam int CW  = $clog2(stc_pkg::SPAN_QBITS + 1);
  localparam int SPW = 21;               // tread * |angle|

  // latched request
  logic              turn_right_q;
  logic [10:0]       angle_q;
  logic [6:0]        base_q;
  logic signed [31:0] lcnt_q, rcnt_q;

  // turn state
  stc_pkg::dir_t      left_dir, right_dir;
  logic signed [GW-1:0] left_goal, right_goal;
  logic [31:0]        span;
  logic [6:0]         peak;
  logic [7:0]         left_drive, right_drive;

  // work registers
  logic [RW-1:0] rem_mag;
  logic [NW-1:0] prod;
  logic [NW-1:0] dv_rem, dv_den;
  logic [31:0]   dv_quo;
  logic [CW-1:0] dv_cnt;
  logic          dv_sat;

  // span division operands
  logic [10:0]    ang_mag;
  logic [SPW-1:0] start_prod;
  logic [7:0]     rad_eff;
  logic [8:0]     start_div;
  logic [NW-1:0]  start_num;
  logic           start_sat;
  logic           tick_sat;

  assign ang_mag    = angle_q[10] ? (~angle_q + 11'd1) : angle_q;
  assign start_prod = {11'b0, tread} * {10'b0, ang_mag};
  assign rad_eff    = (radius == 8'd0) ? 8'd1 : radius;
  assign start_div  = {rad_eff, 1'b0};
  assign start_num  = NW'(start_prod) << FRAC_BITS;
  assign start_sat  = start_num >= (NW'(start_div) << stc_pkg::SPAN_QBITS);
  assign tick_sat   = prod >= (NW'(span) << stc_pkg::PWM_QBITS);

  // fixed-point counts and goals
  logic signed [GW-1:0] lcnt_fx, rcnt_fx, span_gw;
  logic [31:0]          span_val;

  assign lcnt_fx  = GW'(lcnt_q) <<< FRAC_BITS;
  assign rcnt_fx  = GW'(rcnt_q) <<< FRAC_BITS;
  assign span_val = dv_sat ? 32'hFFFF_FFFF : dv_quo;
  assign span_gw  = $signed(GW'(span_val));

  // selected wheel
  stc_pkg::dir_t        dir_sel;
  logic signed [GW-1:0] diff, rem_s;
  logic                 moving;

  assign dir_sel = (cmd_i.sel == stc_pkg::WHEEL_RIGHT) ? right_dir : left_dir;
  assign diff    = (cmd_i.sel == stc_pkg::WHEEL_RIGHT) ? (right_goal - rcnt_fx)
                                                       : (left_goal - lcnt_fx);
  assign rem_s   = (dir_sel == stc_pkg::DIR_FWD) ? diff : -diff;
  assign moving  = (dir_sel != stc_pkg::DIR_STOP) && !rem_s[GW-1] && (rem_s != '0);

  logic [RW+6:0] mul_out;
  assign mul_out = {7'b0, rem_mag} * {{RW{1'b0}}, peak};

  // drive from quotient: floor, raise to min, clamp at limit
  logic [6:0] q7, m_lo, m_hi;
  logic [7:0] drive_mag, drive_val;

  assign q7        = dv_quo[6:0];
  assign m_lo      = (q7 < min_pwm) ? min_pwm : q7;
  assign m_hi      = (dv_sat || (m_lo > stc_pkg::PWM_LIMIT)) ? stc_pkg::PWM_LIMIT : m_lo;
  assign drive_mag = {1'b0, m_hi};
  assign drive_val = (dir_sel == stc_pkg::DIR_FWD) ? drive_mag : (~drive_mag + 8'd1);

  assign sts_o.div_done = (dv_cnt == '0);
  assign sts_o.moving   = moving;
  assign sts_o.out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_dir   <= stc_pkg::DIR_STOP;
      right_dir  <= stc_pkg::DIR_STOP;
      left_goal  <= '0;
      right_goal <= '0;
      span       <= '0;
      peak       <= '0;
      dv_cnt     <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cmd_i.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cmd_i.goal_set) begin
        span <= span_val;
        peak <= base_q;
        if (turn_right_q) begin
          left_dir   <= stc_pkg::DIR_FWD;
          right_dir  <= stc_pkg::DIR_REV;
          left_goal  <= lcnt_fx + span_gw;
          right_goal <= rcnt_fx - span_gw;
        end else begin
          left_dir   <= stc_pkg::DIR_REV;
          right_dir  <= stc_pkg::DIR_FWD;
          left_goal  <= lcnt_fx - span_gw;
          right_goal <= rcnt_fx + span_gw;
        end
      end
      if (cmd_i.check && !moving) begin
        if (cmd_i.sel == stc_pkg::WHEEL_RIGHT) begin
          right_dir <= stc_pkg::DIR_STOP;
        end else begin
          left_dir <= stc_pkg::DIR_STOP;
        end
      end
      if (cmd_i.div_load) begin
        dv_cnt <= cmd_i.div_span ? CW'(stc_pkg::SPAN_QBITS) : CW'(stc_pkg::PWM_QBITS);
      end else if (cmd_i.div_step) begin
        dv_cnt <= dv_cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.latch) begin
      turn_right_q <= turn_right;
      angle_q      <= angle_deg;
      base_q       <= base_pwm;
      lcnt_q       <= left_count;
      rcnt_q       <= right_count;
    end
    if (cmd_i.goal_set) begin
      left_drive  <= '0;
      right_drive <= '0;
    end
    if (cmd_i.check) begin
      rem_mag <= rem_s[RW-1:0];
      if (!moving) begin
        if (cmd_i.sel == stc_pkg::WHEEL_RIGHT) begin
          right_drive <= '0;
        end else begin
          left_drive <= '0;
        end
      end
    end
    if (cmd_i.mul) begin
      prod <= NW'(mul_out);
    end
    if (cmd_i.div_load) begin
      dv_quo <= '0;
      if (cmd_i.div_span) begin
        dv_rem <= start_num;
        dv_den <= NW'(start_div) << (stc_pkg::SPAN_QBITS - 1);
        dv_sat <= start_sat;
      end else begin
        dv_rem <= prod;
        dv_den <= NW'(span) << (stc_pkg::PWM_QBITS - 1);
        dv_sat <= tick_sat;
      end
    end else if (cmd_i.div_step) begin
      if (dv_rem >= dv_den) begin
        dv_rem <= dv_rem - dv_den;
        dv_quo <= {dv_quo[30:0], 1'b1};
      end else begin
        dv_quo <= {dv_quo[30:0], 1'b0};
      end
      dv_den <= dv_den >> 1;
    end
    if (cmd_i.pwm_set) begin
      if (cmd_i.sel == stc_pkg::WHEEL_RIGHT) begin
        right_drive <= drive_val;
      end else begin
        left_drive <= drive_val;
      end
    end
    if (cmd_i.out_load) begin
      left_pwm  <= left_drive;
      right_pwm <= right_drive;
      turn_done <= (left_dir == stc_pkg::DIR_STOP) && (right_dir == stc_pkg::DIR_STOP);
    end
  end

  `STC_CHECK_NEXT(a_load_sets_valid, cmd_i.out_load, rsp_valid, "loaded result not presented")
  `STC_CHECK_NOW(a_done_is_stopped, (rsp_valid && turn_done), (left_pwm == 8'sd0 && right_pwm == 8'sd0), "turn done with a wheel still driven")
  `STC_CHECK_NOW(a_pwm_in_range, rsp_valid, (left_pwm <= 8'sd100 && left_pwm >= -8'sd100 && right_pwm <= 8'sd100 && right_pwm >= -8'sd100), "drive outside limit")

endmodule

`default_nettype wire

FILE: rtl/spin_turn_wheel_controller_top.sv
// Top level of the spin turn wheel controller: APB registers, sequencer and datapath.
`default_nettype none

// Turn-in-place controller for a two-wheel drive. A start request (cmd 0)
// latches opposite-signed wheel goals, span = tread * |angle| / (2 * radius)
// in Q.FRAC_BITS encoder degrees, and answers 0, 0, not done. Each tick
// (cmd 1) drives each wheel with remaining * start base_pwm / span, raised to
// min_pwm and limited to 100, or 0 once that wheel reached its goal; turn_done
// is high when both wheels are finished. All divisions run on one shared
// restoring divider, one quotient bit per cycle: a start divides for 32 span
// quotient bits, a tick for 7 drive quotient bits per moving wheel. One
// request is worked at a time; the finished result waits in an output
// register while the next request is taken. Registers: tread at 0x0,
// radius at 0x4, min_pwm at 0x8.

module spin_turn_wheel_controller_top #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               req_valid,
  output logic               req_stall,
  input  logic               cmd,
  input  logic               turn_right,
  input  logic signed [10:0] angle_deg,
  input  logic [6:0]         base_pwm,
  input  logic signed [31:0] left_count,
  input  logic signed [31:0] right_count,
  // result channel
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic signed [7:0]  left_pwm,
  output logic signed [7:0]  right_pwm,
  output logic               turn_done,
  // APB
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [9:0] tread;
  logic [7:0] radius;
  logic [6:0] min_pwm;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tread   <= stc_pkg::TREAD_RST;
      radius  <= stc_pkg::RADIUS_RST;
      min_pwm <= stc_pkg::MIN_PWM_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        stc_pkg::REG_TREAD:   tread   <= pwdata[9:0];
        stc_pkg::REG_RADIUS:  radius  <= pwdata[7:0];
        stc_pkg::REG_MIN_PWM: min_pwm <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      stc_pkg::REG_TREAD:   prdata = {22'b0, tread};
      stc_pkg::REG_RADIUS:  prdata = {24'b0, radius};
      stc_pkg::REG_MIN_PWM: prdata = {25'b0, min_pwm};
      default:              prdata = '0;
    endcase
  end

  stc_pkg::ctrl_cmd_t ctl_cmd;
  stc_pkg::status_t   dp_sts;

  stc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .cmd       (cmd),
    .req_stall (req_stall),
    .sts_i     (dp_sts),
    .cmd_o     (ctl_cmd)
  );

  stc_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd_i       (ctl_cmd),
    .sts_o       (dp_sts),
    .tread       (tread),
    .radius      (radius),
    .min_pwm     (min_pwm),
    .turn_right  (turn_right),
    .angle_deg   (angle_deg),
    .base_pwm    (base_pwm),
    .left_count  (left_count),
    .right_count (right_count),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .left_pwm    (left_pwm),
    .right_pwm   (right_pwm),
    .turn_done   (turn_done)
  );

endmodule

`default_nettype wire
